@@ hdl/music_macro_tune_parser_assert.svh @@
// Assertion macros for the tune parser.
// Included by modules that carry concurrent assertions.
`ifndef MUSIC_MACRO_TUNE_PARSER_ASSERT_SVH
`define MUSIC_MACRO_TUNE_PARSER_ASSERT_SVH

// same-cycle implication
`define MMTP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MMTP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/mmtp_pkg.sv @@
// Shared types, field widths, event codes and the note frequency table.
// No dependencies.
`timescale 1ns / 1ps

package mmtp_pkg;

  localparam int CHAR_BITS  = 8;
  localparam int KIND_BITS  = 2;
  localparam int FREQ_BITS  = 13;
  localparam int DUR_BITS   = 24;
  localparam int GAP_BITS   = 23;
  localparam int POWER_BITS = 8;
  localparam int NOTE_BITS  = 7;
  localparam int TIME_BITS  = 28;
  localparam int ROM_SIZE   = 84;

  localparam logic [KIND_BITS-1:0] KIND_NOTE  = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_REST  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_END   = 2'd2;
  localparam logic [KIND_BITS-1:0] KIND_ERROR = 2'd3;

  localparam logic [TIME_BITS-1:0] WHOLE_NOTE_US = 28'd240000000;

  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [FREQ_BITS-1:0]  freq;
    logic [DUR_BITS-1:0]   dur;
    logic [GAP_BITS-1:0]   gap;
    logic [POWER_BITS-1:0] pwr;
    logic                  rep;
  } result_t;

  localparam logic [FREQ_BITS-1:0] FREQ_TABLE [ROM_SIZE] = '{
    13'd65, 13'd69, 13'd73, 13'd77, 13'd82, 13'd87, 13'd92, 13'd97, 13'd103,
    13'd110, 13'd116, 13'd123, 13'd130, 13'd138, 13'd146, 13'd155, 13'd164,
    13'd174, 13'd184, 13'd195, 13'd207,
    13'd220, 13'd233, 13'd246, 13'd261, 13'd277, 13'd293, 13'd311, 13'd329,
    13'd349, 13'd369, 13'd391, 13'd415,
    13'd440, 13'd466, 13'd493, 13'd523, 13'd554, 13'd587, 13'd622, 13'd659,
    13'd698, 13'd739, 13'd783, 13'd830,
    13'd880, 13'd932, 13'd987, 13'd1046, 13'd1108, 13'd1174, 13'd1244,
    13'd1318, 13'd1396, 13'd1479, 13'd1567, 13'd1661,
    13'd1760, 13'd1864, 13'd1975, 13'd2093, 13'd2217, 13'd2349, 13'd2489,
    13'd2637, 13'd2793, 13'd2959, 13'd3135, 13'd3322,
    13'd3520, 13'd3729, 13'd3951, 13'd4186, 13'd4434, 13'd4698, 13'd4978,
    13'd5274, 13'd5587, 13'd5919, 13'd6271, 13'd6644,
    13'd7040, 13'd7458, 13'd7902
  };

  function automatic logic [FREQ_BITS-1:0] note_freq(input logic [NOTE_BITS-1:0] note);
    logic [NOTE_BITS-1:0] idx;
    idx = note - 7'd1;
    if (note >= 7'd1 && note <= 7'(ROM_SIZE)) begin
      return FREQ_TABLE[idx];
    end
    return '0;
  endfunction

  // semitone of letters A..G, index 0 = A
  function automatic logic [3:0] semitone(input logic [2:0] idx);
    case (idx)
      3'd0:    return 4'd9;
      3'd1:    return 4'd11;
      3'd2:    return 4'd0;
      3'd3:    return 4'd2;
      3'd4:    return 4'd4;
      3'd5:    return 4'd5;
      3'd6:    return 4'd7;
      default: return 4'd0;
    endcase
  endfunction

endpackage

@@ hdl/mmtp_ifs.sv @@
// Channel interfaces: tune characters in, events out, power register write.
// Depends on mmtp_pkg.
`timescale 1ns / 1ps

interface mmtp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [mmtp_pkg::CHAR_BITS-1:0] char_code;
  logic                           last;
  modport source (output valid, func, char_code, last, input ready);
  modport sink (input valid, func, char_code, last, output ready);
endinterface

interface mmtp_out_if;
  logic                            valid;
  logic                            ready;
  logic [mmtp_pkg::KIND_BITS-1:0]  event_kind;
  logic [mmtp_pkg::FREQ_BITS-1:0]  frequency_hz;
  logic [mmtp_pkg::DUR_BITS-1:0]   duration_us;
  logic [mmtp_pkg::GAP_BITS-1:0]   gap_us;
  logic [mmtp_pkg::POWER_BITS-1:0] power_level;
  logic                            repeat_flag;
  logic                            last_result;
  modport source (output valid, event_kind, frequency_hz, duration_us, gap_us,
                  power_level, repeat_flag, last_result, input ready);
  modport sink (input valid, event_kind, frequency_hz, duration_us, gap_us,
                power_level, repeat_flag, last_result, output ready);
endinterface

interface mmtp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mmtp_pkg::POWER_BITS-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ hdl/mmtp_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Standalone; used by the tune parser sequencer.
`timescale 1ns / 1ps

module mmtp_div #(
  parameter int DW = 28,
  parameter int VW = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] rem;
  logic [VW-1:0] dvs;
  logic [DW-1:0] quo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   rem_sh;
  logic [VW+1:0] diff;
  logic          borrow;

  assign rem_sh   = {rem, quo[DW-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs};
  assign borrow   = diff[VW+1];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= CW'(DW);
      end else if (busy) begin
        rem <= borrow ? rem_sh[VW-1:0] : diff[VW-1:0];
        quo <= {quo[DW-2:0], ~borrow};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/music_macro_tune_parser.sv @@
// Music macro language tune parser: top level sequencer.
// Depends on mmtp_pkg, mmtp_ifs, mmtp_div and the assertion header.
//
// Usage:
//   tune   : one item per character (func, char_code, last). func starts a
//            new tune. Ready only while the sequencer is idle.
//   events : note, rest, end and error events; last_result marks the final
//            event caused by an input item.
//   cfg    : writes tone_power, always ready; write only while idle.
// Note path:
//   Completing a note or rest runs two serial divisions on the shared
//   divider (whole period by tempo, then by length), adds one extension
//   per dot and hands the result to the hold stage; a stalled output
//   delays that handoff.
// Reset: rst (synchronous) restores tempo 120, length 4, octave 4, normal
//   articulation, tone_power 30, and leaves the tune inactive.
// Stall: results wait in a hold stage and an output register; the sequencer
//   halts until the output register frees up, dropping nothing.
`timescale 1ns / 1ps
`include "music_macro_tune_parser_assert.svh"

module music_macro_tune_parser #(
  parameter int HIGHEST_NOTE = 84,
  parameter int NUMBER_BITS  = 16,
  parameter int MAX_OCTAVE   = 6
) (
  input logic       clk,
  input logic       rst,
  mmtp_cfg_if.sink  cfg,
  mmtp_in_if.sink   tune,
  mmtp_out_if.source events
);

  localparam int NB = NUMBER_BITS;
  localparam int TB = mmtp_pkg::TIME_BITS;
  localparam logic [NB-1:0] NUM_CAP = {NB{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;

  localparam logic [1:0] ART_NORMAL   = 2'd0;
  localparam logic [1:0] ART_LEGATO   = 2'd1;
  localparam logic [1:0] ART_STACCATO = 2'd2;

  localparam logic [3:0] DOTS_MAX = 4'd15;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_FEED      = 7'b0000010,
    ST_DIV_WHOLE = 7'b0000100,
    ST_DIV_LEN   = 7'b0001000,
    ST_DOTS      = 7'b0010000,
    ST_PUSH      = 7'b0100000,
    ST_FIN       = 7'b1000000
  } state_t;

  typedef enum logic [9:0] {
    PH_IDLE  = 10'b0000000001,
    PH_LEN   = 10'b0000000010,
    PH_OCT   = 10'b0000000100,
    PH_TEMPO = 10'b0000001000,
    PH_MODE  = 10'b0000010000,
    PH_REST  = 10'b0000100000,
    PH_NNUM  = 10'b0001000000,
    PH_ACC   = 10'b0010000000,
    PH_NLEN  = 10'b0100000000,
    PH_DOT   = 10'b1000000000
  } phase_t;

  state_t                state;
  phase_t                phase;
  logic [7:0]            tone_power;
  logic [7:0]            tempo;
  logic [NB-1:0]         deflen;
  logic [NB-1:0]         accum;
  logic [3:0]            octave;
  logic [3:0]            dots;
  logic [3:0]            dots_left;
  logic [1:0]            artic;
  logic                  repeat_on;
  logic                  active;
  logic                  last_pend;
  logic                  cont;
  logic [7:0]            ch;
  logic [6:0]            pnote;
  logic [TB-1:0]         dur;
  logic [TB-1:0]         ext;
  logic [TB-1:0]         gap;
  mmtp_pkg::result_t     res;
  mmtp_pkg::result_t     hold;
  logic                  hold_valid;
  mmtp_pkg::result_t     out_r;
  logic                  out_last;
  logic                  out_valid;

  logic                  div_start;
  logic                  div_done;
  logic [TB-1:0]         div_a;
  logic [NB-1:0]         div_b;
  logic [TB-1:0]         div_q;

  logic [7:0]            folded;
  logic                  in_space;
  logic                  is_digit;
  logic                  is_letter;
  logic [NB+3:0]         digit_sum;
  logic [NB-1:0]         accum_dig;
  logic [6:0]            letter_note;
  logic [TB-1:0]         gap_c;
  logic [TB-1:0]         base_c;
  logic                  out_free;

  assign folded   = (tune.char_code >= CH_LA && tune.char_code <= CH_LZ) ?
                    tune.char_code - 8'd32 : tune.char_code;
  assign in_space = (folded == CH_SPACE) || (folded >= CH_TAB && folded <= CH_CR);
  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign is_letter = (ch >= CH_A) && (ch <= CH_G);

  assign digit_sum = ({4'b0000, accum} << 3) + ({4'b0000, accum} << 1)
                   + {{NB{1'b0}}, ch[3:0]};
  assign accum_dig = (digit_sum[NB+3:NB] != 4'd0) ? NUM_CAP : digit_sum[NB-1:0];

  assign letter_note = 7'(mmtp_pkg::semitone(ch[2:0] - 3'd1))
                     + ({3'b000, octave} << 3) + ({3'b000, octave} << 2) + 7'd1;

  assign out_free = !out_valid || events.ready;

  // shared divider: whole period by tempo, then by note length
  assign div_start = (state == ST_FEED && phase == PH_DOT && ch != CH_DOT)
                  || (state == ST_DIV_WHOLE && div_done);
  assign div_a = (state == ST_FEED) ? mmtp_pkg::WHOLE_NOTE_US : div_q;
  always_comb begin
    if (state == ST_FEED) begin
      div_b = (tempo == 8'd0) ? NB'(1) : NB'(tempo);
    end else begin
      div_b = (accum == '0) ? NB'(1) : accum;
    end
  end

  always_comb begin
    gap_c = '0;
    if (pnote != 7'd0) begin
      if (artic == ART_NORMAL) begin
        gap_c = div_q >> 3;
      end else if (artic == ART_STACCATO) begin
        gap_c = div_q >> 2;
      end
    end
    base_c = div_q - gap_c;
  end

  mmtp_div #(.DW(TB), .VW(NB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    logic done;
    logic fail;
    logic fin;
    logic clr;
    done = 1'b0;
    fail = 1'b0;
    fin  = 1'b0;
    clr  = 1'b0;
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_IDLE;
      tone_power <= 8'd30;
      tempo      <= 8'd120;
      deflen     <= NB'(4);
      accum      <= '0;
      octave     <= 4'd4;
      dots       <= '0;
      artic      <= ART_NORMAL;
      repeat_on  <= 1'b0;
      pnote      <= '0;
      active     <= 1'b0;
      last_pend  <= 1'b0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        tone_power <= cfg.data;
      end
      if (out_valid && events.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (tune.valid) begin
            if (tune.func) begin
              clr = 1'b1;
              active    <= 1'b1;
              ch        <= CH_NUL;
              last_pend <= 1'b0;
              state     <= tune.last ? ST_FEED : ST_FIN;
            end else if (!active) begin
              state <= ST_FIN;
            end else if (folded == CH_NUL) begin
              ch        <= CH_NUL;
              last_pend <= 1'b0;
              state     <= ST_FEED;
            end else if (in_space) begin
              ch        <= CH_NUL;
              last_pend <= 1'b0;
              state     <= tune.last ? ST_FEED : ST_FIN;
            end else begin
              ch        <= folded;
              last_pend <= tune.last;
              state     <= ST_FEED;
            end
          end
        end
        ST_FEED: begin
          unique case (phase)
            PH_LEN: begin
              if (is_digit) begin
                accum <= accum_dig;
                done = 1'b1;
              end else if (accum == '0) begin
                fail = 1'b1;
              end else begin
                deflen <= accum;
                phase  <= PH_IDLE;
              end
            end
            PH_OCT: begin
              if (is_digit) begin
                accum <= accum_dig;
                done = 1'b1;
              end else begin
                octave <= (accum > NB'(MAX_OCTAVE)) ? 4'(MAX_OCTAVE) : accum[3:0];
                phase  <= PH_IDLE;
              end
            end
            PH_TEMPO: begin
              if (is_digit) begin
                accum <= accum_dig;
                done = 1'b1;
              end else if (accum < NB'(32) || accum > NB'(255)) begin
                fail = 1'b1;
              end else begin
                tempo <= accum[7:0];
                phase <= PH_IDLE;
              end
            end
            PH_MODE: begin
              phase <= PH_IDLE;
              if (ch == CH_N) begin
                artic <= ART_NORMAL;
                done = 1'b1;
              end else if (ch == CH_L) begin
                artic <= ART_LEGATO;
                done = 1'b1;
              end else if (ch == CH_S) begin
                artic <= ART_STACCATO;
                done = 1'b1;
              end else if (ch == CH_F) begin
                repeat_on <= 1'b0;
                done = 1'b1;
              end else if (ch == CH_B) begin
                repeat_on <= 1'b1;
                done = 1'b1;
              end else begin
                fail = 1'b1;
              end
            end
            PH_REST: begin
              if (is_digit) begin
                accum <= accum_dig;
                done = 1'b1;
              end else begin
                phase <= PH_DOT;
              end
            end
            PH_NNUM: begin
              if (is_digit) begin
                accum <= accum_dig;
                done = 1'b1;
              end else if (accum > NB'(HIGHEST_NOTE)) begin
                fail = 1'b1;
              end else begin
                pnote <= accum[6:0];
                accum <= deflen;
                phase <= PH_DOT;
              end
            end
            PH_ACC: begin
              phase <= PH_NLEN;
              if (ch == CH_HASH || ch == CH_PLUS) begin
                if (pnote < 7'(HIGHEST_NOTE)) begin
                  pnote <= pnote + 7'd1;
                end
                done = 1'b1;
              end else if (ch == CH_MINUS) begin
                if (pnote > 7'd1) begin
                  pnote <= pnote - 7'd1;
                end
                done = 1'b1;
              end
            end
            PH_NLEN: begin
              if (is_digit) begin
                accum <= accum_dig;
                done = 1'b1;
              end else begin
                if (accum == '0) begin
                  accum <= deflen;
                end
                phase <= PH_DOT;
              end
            end
            PH_DOT: begin
              if (ch == CH_DOT) begin
                if (dots < DOTS_MAX) begin
                  dots <= dots + 4'd1;
                end
                done = 1'b1;
              end else begin
                state <= ST_DIV_WHOLE;
              end
            end
            PH_IDLE: begin
              unique case (ch)
                CH_NUL: fin = 1'b1;
                CH_L: begin
                  phase <= PH_LEN;
                  accum <= '0;
                  dots  <= '0;
                  done = 1'b1;
                end
                CH_O: begin
                  phase <= PH_OCT;
                  accum <= '0;
                  dots  <= '0;
                  done = 1'b1;
                end
                CH_T: begin
                  phase <= PH_TEMPO;
                  accum <= '0;
                  dots  <= '0;
                  done = 1'b1;
                end
                CH_M: begin
                  phase <= PH_MODE;
                  done = 1'b1;
                end
                CH_P: begin
                  phase <= PH_REST;
                  accum <= '0;
                  dots  <= '0;
                  pnote <= '0;
                  done = 1'b1;
                end
                CH_N: begin
                  phase <= PH_NNUM;
                  accum <= '0;
                  dots  <= '0;
                  done = 1'b1;
                end
                CH_LT: begin
                  if (octave != 4'd0) begin
                    octave <= octave - 4'd1;
                  end
                  done = 1'b1;
                end
                CH_GT: begin
                  if (octave < 4'(MAX_OCTAVE)) begin
                    octave <= octave + 4'd1;
                  end
                  done = 1'b1;
                end
                default: begin
                  if (is_letter) begin
                    pnote <= letter_note;
                    phase <= PH_ACC;
                    accum <= '0;
                    dots  <= '0;
                    done = 1'b1;
                  end else begin
                    fail = 1'b1;
                  end
                end
              endcase
            end
            default: phase <= PH_IDLE;
          endcase
          if (fail) begin
            res       <= '{kind: mmtp_pkg::KIND_ERROR, default: '0};
            clr = 1'b1;
            active    <= 1'b0;
            cont      <= 1'b0;
            state     <= ST_PUSH;
          end
          if (fin) begin
            res       <= '{kind: mmtp_pkg::KIND_END, rep: repeat_on, default: '0};
            clr = 1'b1;
            active    <= repeat_on;
            cont      <= 1'b0;
            state     <= ST_PUSH;
          end
          if (done) begin
            if (last_pend && active) begin
              ch        <= CH_NUL;
              last_pend <= 1'b0;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_DIV_WHOLE: begin
          if (div_done) begin
            state <= ST_DIV_LEN;
          end
        end
        ST_DIV_LEN: begin
          if (div_done) begin
            dur       <= base_c;
            ext       <= base_c >> 1;
            gap       <= gap_c;
            dots_left <= dots;
            state     <= ST_DOTS;
          end
        end
        ST_DOTS: begin
          if (dots_left != 4'd0) begin
            dur       <= dur + ext;
            ext       <= ext >> 1;
            dots_left <= dots_left - 4'd1;
          end else begin
            if (pnote == 7'd0) begin
              res <= '{kind: mmtp_pkg::KIND_REST, dur: dur[mmtp_pkg::DUR_BITS-1:0],
                       default: '0};
            end else begin
              res <= '{kind: mmtp_pkg::KIND_NOTE,
                       freq: mmtp_pkg::note_freq(pnote),
                       dur:  dur[mmtp_pkg::DUR_BITS-1:0],
                       gap:  gap[mmtp_pkg::GAP_BITS-1:0],
                       pwr:  tone_power,
                       rep:  1'b0};
            end
            phase <= PH_IDLE;
            accum <= '0;
            dots  <= '0;
            pnote <= '0;
            cont  <= 1'b1;
            state <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              out_r     <= hold;
              out_last  <= 1'b0;
              out_valid <= 1'b1;
            end
            hold       <= res;
            hold_valid <= 1'b1;
            if (cont) begin
              state <= ST_FEED;
            end else if (last_pend && active) begin
              ch        <= CH_NUL;
              last_pend <= 1'b0;
              state     <= ST_FEED;
            end else begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (!hold_valid) begin
            state <= ST_IDLE;
          end else if (out_free) begin
            out_r      <= hold;
            out_last   <= 1'b1;
            out_valid  <= 1'b1;
            hold_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (clr) begin
        tempo     <= 8'd120;
        deflen    <= NB'(4);
        octave    <= 4'd4;
        artic     <= ART_NORMAL;
        repeat_on <= 1'b0;
        phase     <= PH_IDLE;
        accum     <= '0;
        dots      <= '0;
        pnote     <= '0;
      end
    end
  end

  assign tune.ready         = (state == ST_IDLE);
  assign cfg.ready          = 1'b1;
  assign events.valid       = out_valid;
  assign events.event_kind  = out_r.kind;
  assign events.frequency_hz = out_r.freq;
  assign events.duration_us = out_r.dur;
  assign events.gap_us      = out_r.gap;
  assign events.power_level = out_r.pwr;
  assign events.repeat_flag = out_r.rep;
  assign events.last_result = out_last;

  `MMTP_ASSERT_IMP(a_idle_hold_empty, clk, rst, state == ST_IDLE, !hold_valid, "hold not drained")
  `MMTP_ASSERT_IMP(a_inactive_phase, clk, rst, state == ST_IDLE && !active, phase == PH_IDLE, "stale phase")
  `MMTP_ASSERT_IMP(a_tempo_range, clk, rst, 1'b1, tempo >= 8'd32, "tempo below range")
  `MMTP_ASSERT_IMP(a_div_owner, clk, rst, div_done, state == ST_DIV_WHOLE || state == ST_DIV_LEN, "stray divide")
  `MMTP_ASSERT_NXT(a_fin_last, clk, rst, state == ST_FIN && hold_valid && out_free, out_valid && out_last, "final item unmarked")

endmodule
